[sv/shp_pkg.sv]
// package: shared types, constants and reset values of the spa heat pump controller
`default_nettype none
package shp_pkg;

  localparam int unsigned SecW  = 16;
  localparam int unsigned SpW   = 10;
  localparam int unsigned BandW = 6;
  localparam int unsigned TempW = 11;
  localparam int unsigned UpdW  = 4;

  localparam int unsigned NumRegs  = 8;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned PaddrW   = 5;
  localparam int unsigned PdataW   = 32;

  localparam logic [UpdW-1:0] UpdateSecondsDefault = 4'd2;

  localparam logic [SpW-1:0] SetpointReset = 10'd408;
  localparam logic [SpW-1:0] SetpointMax   = 10'd1023;
  localparam logic [SpW-1:0] SetpointStep  = 10'd4;

  typedef enum logic [RegIdxW-1:0] {
    REG_PUMP_IDLE    = 3'd0,
    REG_PUMP_RUN     = 3'd1,
    REG_AFTER_RUN    = 3'd2,
    REG_BLOWER_LIMIT = 3'd3,
    REG_SP_FLOOR     = 3'd4,
    REG_SP_CEILING   = 3'd5,
    REG_BAND_BELOW   = 3'd6,
    REG_BAND_ABOVE   = 3'd7
  } reg_idx_e;

  localparam logic [SecW-1:0]  PumpIdleReset    = 16'd25200;
  localparam logic [SecW-1:0]  PumpRunReset     = 16'd1800;
  localparam logic [SecW-1:0]  AfterRunReset    = 16'd600;
  localparam logic [SecW-1:0]  BlowerLimitReset = 16'd1800;
  localparam logic [SpW-1:0]   SpFloorReset     = 10'd380;
  localparam logic [SpW-1:0]   SpCeilingReset   = 10'd420;
  localparam logic [BandW-1:0] BandBelowReset   = 6'd3;
  localparam logic [BandW-1:0] BandAboveReset   = 6'd2;

  typedef struct packed {
    logic [SecW-1:0]  pump_idle_seconds;
    logic [SecW-1:0]  pump_run_seconds;
    logic [SecW-1:0]  after_run_seconds;
    logic [SecW-1:0]  blower_limit_seconds;
    logic [SpW-1:0]   setpoint_floor;
    logic [SpW-1:0]   setpoint_ceiling;
    logic [BandW-1:0] band_below;
    logic [BandW-1:0] band_above;
  } cfg_t;

  typedef struct packed {
    logic                    sec_tick;
    logic                    up_press;
    logic                    down_press;
    logic                    blower_press;
    logic                    standby_press;
    logic signed [TempW-1:0] tub_temp;
  } in_item_t;

  typedef struct packed {
    logic           heater_on;
    logic           pump_on;
    logic           blower_on;
    logic           in_standby;
    logic [SpW-1:0] setpoint_now;
    logic           circulating;
  } out_item_t;

endpackage
`default_nettype wire

[sv/shp_in_if.sv]
// interface: input item channel
`default_nettype none
interface shp_in_if;
  logic                                valid;
  logic                                ready;
  logic                                sec_tick;
  logic                                up_press;
  logic                                down_press;
  logic                                blower_press;
  logic                                standby_press;
  logic signed [shp_pkg::TempW-1:0]    tub_temp;

  modport source (
    output valid, sec_tick, up_press, down_press, blower_press, standby_press, tub_temp,
    input  ready
  );
  modport sink (
    input  valid, sec_tick, up_press, down_press, blower_press, standby_press, tub_temp,
    output ready
  );
endinterface
`default_nettype wire

[sv/shp_out_if.sv]
// interface: result item channel
`default_nettype none
interface shp_out_if;
  logic                       valid;
  logic                       ready;
  logic                       heater_on;
  logic                       pump_on;
  logic                       blower_on;
  logic                       in_standby;
  logic [shp_pkg::SpW-1:0]    setpoint_now;
  logic                       circulating;

  modport source (
    output valid, heater_on, pump_on, blower_on, in_standby, setpoint_now, circulating,
    input  ready
  );
  modport sink (
    input  valid, heater_on, pump_on, blower_on, in_standby, setpoint_now, circulating,
    output ready
  );
endinterface
`default_nettype wire

[sv/spa_heat_pump_controller.sv]
// top level: spa heat pump controller with item channels and apb configuration
`default_nettype none
// One input item is one pass of the controller loop: button presses, a one-second
// tick and the tub temperature. Each item yields exactly one result item with the
// relay drives, standby flag, current setpoint and circulation request. An item is
// captured in an input register, worked through in combinational logic against the
// controller state and lands in a result register; one item is taken every cycle
// while the result side keeps taking results; a stalled result holds one result
// plus one item in the input register. The user must write configuration over the
// apb port only while no item is in flight; the block does not enforce this. New
// timer lengths take effect at the next load of the timer concerned.
module spa_heat_pump_controller #(
  parameter logic [shp_pkg::UpdW-1:0] UPDATE_SECONDS = shp_pkg::UpdateSecondsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  shp_in_if.sink                             in_i,
  shp_out_if.source                          out_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [shp_pkg::PaddrW-1:0]    paddr,
  input  wire logic [shp_pkg::PdataW-1:0]    pwdata,
  output logic      [shp_pkg::PdataW-1:0]    prdata,
  output logic                               pready
);
  import shp_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  out_item_t res, out_q;
  logic      in_vld_q, out_vld_q;
  logic      advance, step;

  // result register is free or being drained this cycle
  assign advance  = !out_vld_q || out_o.ready;
  // the buffered item is processed and moves to the result register
  assign step     = in_vld_q && advance;
  assign in_i.ready = !in_vld_q || advance;

  shp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  shp_core #(
    .UPDATE_SECONDS (UPDATE_SECONDS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q.sec_tick      <= in_i.sec_tick;
      in_q.up_press      <= in_i.up_press;
      in_q.down_press    <= in_i.down_press;
      in_q.blower_press  <= in_i.blower_press;
      in_q.standby_press <= in_i.standby_press;
      in_q.tub_temp      <= in_i.tub_temp;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) out_q <= res;
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.heater_on    = out_q.heater_on;
  assign out_o.pump_on      = out_q.pump_on;
  assign out_o.blower_on    = out_q.blower_on;
  assign out_o.in_standby   = out_q.in_standby;
  assign out_o.setpoint_now = out_q.setpoint_now;
  assign out_o.circulating  = out_q.circulating;

`ifndef ASSERT_OFF
  // a processed item always shows up as a result next cycle
  a_step_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_vld_q)
    else $error("processed item did not reach the result register");

  // a buffered item is never dropped while the result side stalls
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> in_vld_q)
    else $error("buffered item lost during stall");

  // standby keeps every relay off
  a_standby_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.in_standby) |->
      (!out_q.heater_on && !out_q.pump_on && !out_q.blower_on))
    else $error("relay driven while in standby");

  // heater never runs without the pump
  a_heat_pump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.heater_on) |-> out_q.pump_on)
    else $error("heater on without pump");
`endif

endmodule
`default_nettype wire

[sv/shp_cfg.sv]
// configuration register file with apb-style write and read
`default_nettype none
module shp_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [shp_pkg::PaddrW-1:0]    paddr,
  input  wire logic [shp_pkg::PdataW-1:0]    pwdata,
  output logic      [shp_pkg::PdataW-1:0]    prdata,
  output logic                               pready,
  output shp_pkg::cfg_t                      cfg_o
);
  import shp_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[PaddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pump_idle_seconds    <= PumpIdleReset;
      cfg_q.pump_run_seconds     <= PumpRunReset;
      cfg_q.after_run_seconds    <= AfterRunReset;
      cfg_q.blower_limit_seconds <= BlowerLimitReset;
      cfg_q.setpoint_floor       <= SpFloorReset;
      cfg_q.setpoint_ceiling     <= SpCeilingReset;
      cfg_q.band_below           <= BandBelowReset;
      cfg_q.band_above           <= BandAboveReset;
    end else if (wr_en) begin
      case (idx)
        REG_PUMP_IDLE:    cfg_q.pump_idle_seconds    <= pwdata[SecW-1:0];
        REG_PUMP_RUN:     cfg_q.pump_run_seconds     <= pwdata[SecW-1:0];
        REG_AFTER_RUN:    cfg_q.after_run_seconds    <= pwdata[SecW-1:0];
        REG_BLOWER_LIMIT: cfg_q.blower_limit_seconds <= pwdata[SecW-1:0];
        REG_SP_FLOOR:     cfg_q.setpoint_floor       <= pwdata[SpW-1:0];
        REG_SP_CEILING:   cfg_q.setpoint_ceiling     <= pwdata[SpW-1:0];
        REG_BAND_BELOW:   cfg_q.band_below           <= pwdata[BandW-1:0];
        REG_BAND_ABOVE:   cfg_q.band_above           <= pwdata[BandW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PUMP_IDLE:    prdata = PdataW'(cfg_q.pump_idle_seconds);
      REG_PUMP_RUN:     prdata = PdataW'(cfg_q.pump_run_seconds);
      REG_AFTER_RUN:    prdata = PdataW'(cfg_q.after_run_seconds);
      REG_BLOWER_LIMIT: prdata = PdataW'(cfg_q.blower_limit_seconds);
      REG_SP_FLOOR:     prdata = PdataW'(cfg_q.setpoint_floor);
      REG_SP_CEILING:   prdata = PdataW'(cfg_q.setpoint_ceiling);
      REG_BAND_BELOW:   prdata = PdataW'(cfg_q.band_below);
      REG_BAND_ABOVE:   prdata = PdataW'(cfg_q.band_above);
      default:          prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

[sv/shp_core.sv]
// controller state and the per-item update logic
`default_nettype none
module shp_core #(
  parameter logic [shp_pkg::UpdW-1:0] UPDATE_SECONDS = shp_pkg::UpdateSecondsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire shp_pkg::in_item_t  item_i,
  input  wire shp_pkg::cfg_t      cfg_i,
  output shp_pkg::out_item_t      res_o
);
  import shp_pkg::*;

  logic [SpW-1:0]  sp_q, sp_d;
  logic            stby_q, stby_d, blow_q, blow_d, heat_q, heat_d, pump_q, pump_d;
  logic            reach_q, reach_d, circ_q, circ_d, arr_q, arr_d;
  logic [SecW-1:0] circ_cnt_q, circ_cnt_d, blow_cnt_q, blow_cnt_d, ar_cnt_q, ar_cnt_d;
  logic [UpdW-1:0] upd_cnt_q, upd_cnt_d;

  logic [SpW:0]          sp_up;
  logic [SpW-1:0]        sp_mid;
  logic signed [SpW+1:0] t_ext, hi, lo;

  always_comb begin
    sp_d       = sp_q;
    stby_d     = stby_q;
    blow_d     = blow_q;
    heat_d     = heat_q;
    pump_d     = pump_q;
    reach_d    = reach_q;
    circ_d     = circ_q;
    arr_d      = arr_q;
    circ_cnt_d = circ_cnt_q;
    blow_cnt_d = blow_cnt_q;
    ar_cnt_d   = ar_cnt_q;
    upd_cnt_d  = upd_cnt_q;

    // one-second countdowns, holding at zero
    if (item_i.sec_tick) begin
      if (circ_cnt_d != '0) circ_cnt_d = circ_cnt_d - 1'b1;
      if (blow_cnt_d != '0) blow_cnt_d = blow_cnt_d - 1'b1;
      if (ar_cnt_d != '0)   ar_cnt_d   = ar_cnt_d - 1'b1;
      if (upd_cnt_d != '0)  upd_cnt_d  = upd_cnt_d - 1'b1;
    end

    // setpoint up, saturating at full scale
    sp_up  = {1'b0, sp_q} + {1'b0, SetpointStep};
    sp_mid = sp_q;
    if (item_i.up_press) begin
      stby_d = 1'b0;
      if (sp_q < cfg_i.setpoint_ceiling) begin
        sp_mid = sp_up[SpW] ? SetpointMax : sp_up[SpW-1:0];
      end
    end
    sp_d = sp_mid;
    if (item_i.down_press) begin
      stby_d = 1'b0;
      if (sp_mid > cfg_i.setpoint_floor) begin
        sp_d = (sp_mid < SetpointStep) ? '0 : sp_mid - SetpointStep;
      end
    end

    if (item_i.blower_press) begin
      stby_d = 1'b0;
      blow_d = !blow_d;
      if (blow_d) blow_cnt_d = cfg_i.blower_limit_seconds;
    end

    if (item_i.standby_press) begin
      stby_d = !stby_d;
      if (stby_d) begin
        heat_d = 1'b0;
        pump_d = 1'b0;
        blow_d = 1'b0;
      end
    end

    t_ext = (SpW+2)'(item_i.tub_temp);
    hi    = $signed({2'b00, sp_d}) + $signed({{(SpW+2-BandW){1'b0}}, cfg_i.band_above});
    lo    = $signed({2'b00, sp_d}) - $signed({{(SpW+2-BandW){1'b0}}, cfg_i.band_below});

    if (!stby_d && upd_cnt_d == '0) begin
      if (circ_cnt_d == '0) begin
        circ_d     = !circ_d;
        circ_cnt_d = circ_d ? cfg_i.pump_run_seconds : cfg_i.pump_idle_seconds;
      end
      if (blow_d && blow_cnt_d == '0) blow_d = 1'b0;
      // heating hysteresis
      if (t_ext >= hi) begin
        reach_d = 1'b1;
        heat_d  = 1'b0;
      end else if (reach_d && t_ext <= lo) begin
        reach_d  = 1'b0;
        heat_d   = 1'b1;
        ar_cnt_d = cfg_i.after_run_seconds;
      end else if (!reach_d) begin
        heat_d   = 1'b1;
        ar_cnt_d = cfg_i.after_run_seconds;
      end else begin
        heat_d = 1'b0;
      end
      arr_d  = (ar_cnt_d != '0);
      pump_d = circ_d || heat_d || arr_d;
    end

    if (upd_cnt_d == '0) upd_cnt_d = UPDATE_SECONDS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q       <= SetpointReset;
      stby_q     <= 1'b0;
      blow_q     <= 1'b0;
      heat_q     <= 1'b0;
      pump_q     <= 1'b0;
      reach_q    <= 1'b0;
      circ_q     <= 1'b0;
      arr_q      <= 1'b0;
      circ_cnt_q <= PumpIdleReset;
      blow_cnt_q <= '0;
      ar_cnt_q   <= SecW'(1);
      upd_cnt_q  <= UpdW'(1);
    end else if (step_i) begin
      sp_q       <= sp_d;
      stby_q     <= stby_d;
      blow_q     <= blow_d;
      heat_q     <= heat_d;
      pump_q     <= pump_d;
      reach_q    <= reach_d;
      circ_q     <= circ_d;
      arr_q      <= arr_d;
      circ_cnt_q <= circ_cnt_d;
      blow_cnt_q <= blow_cnt_d;
      ar_cnt_q   <= ar_cnt_d;
      upd_cnt_q  <= upd_cnt_d;
    end
  end

  always_comb begin
    res_o.heater_on    = heat_d;
    res_o.pump_on      = pump_d;
    res_o.blower_on    = blow_d;
    res_o.in_standby   = stby_d;
    res_o.setpoint_now = sp_d;
    res_o.circulating  = circ_d;
  end

endmodule
`default_nettype wire
